FILE: src/sdse_pkg.sv
// Shared constants, types and codes of the static dictionary substitution encoder.
package sdse_pkg;

    localparam int DICT_ENTRIES  = 128;
    localparam int MAX_ENTRY_LEN = 11;

    localparam int IDX_W   = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
    localparam int LIMIT_W = $clog2(DICT_ENTRIES + 1);
    localparam int POS_W   = $clog2(MAX_ENTRY_LEN);
    localparam int LEN_W   = $clog2(MAX_ENTRY_LEN + 1);

    localparam int ENTRY_FIELD_W = 7;
    localparam int POS_FIELD_W   = 4;
    localparam int BYTE_W        = 8;
    localparam int CODE_W        = 8;
    localparam int CFG_W         = 8;
    localparam int CODE_BASE     = 128;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_TEXT = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [IDX_W-1:0]  entry;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_EMIT
    } t_back_state;

endpackage

FILE: src/sdse_front.sv
// Input side: accepts items, drops out-of-range loads, builds queue commands.
module sdse_front (
    input  logic                                  i_push,
    input  logic                                  i_mode,
    input  logic [sdse_pkg::ENTRY_FIELD_W-1:0]    i_entry_index,
    input  logic [sdse_pkg::POS_FIELD_W-1:0]      i_char_pos,
    input  logic [sdse_pkg::BYTE_W-1:0]           i_data_byte,
    input  logic                                  i_last,
    input  logic                                  i_q_full,
    output logic                                  o_full,
    output logic                                  o_q_push,
    output sdse_pkg::t_cmd                        o_cmd
);

    logic w_load_ok;
    logic w_keep;

    always_comb begin
        w_load_ok = ({1'b0, i_entry_index} < (sdse_pkg::ENTRY_FIELD_W + 1)'(sdse_pkg::DICT_ENTRIES))
                 && (i_char_pos < sdse_pkg::POS_FIELD_W'(sdse_pkg::MAX_ENTRY_LEN));
        w_keep    = (sdse_pkg::t_cmd_kind'(i_mode) == sdse_pkg::CMD_TEXT) || w_load_ok;
    end

    always_comb begin
        o_full       = i_q_full;
        o_q_push     = i_push && !i_q_full && w_keep;
        o_cmd.kind   = sdse_pkg::t_cmd_kind'(i_mode);
        o_cmd.entry  = i_entry_index[sdse_pkg::IDX_W-1:0];
        o_cmd.pos    = i_char_pos[sdse_pkg::POS_W-1:0];
        o_cmd.data   = i_data_byte;
        o_cmd.last   = i_last;
    end

endmodule

FILE: src/sdse_cmd_queue.sv
// Short command queue between the front and back parts.
module sdse_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sdse_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output sdse_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    sdse_pkg::t_cmd                    r_slot [sdse_pkg::CMDQ_DEPTH];
    logic [sdse_pkg::CMDQ_PTR_W-1:0]   r_wr_ptr;
    logic [sdse_pkg::CMDQ_PTR_W-1:0]   r_rd_ptr;
    logic [sdse_pkg::CMDQ_CNT_W-1:0]   r_count;
    logic                              w_do_push;
    logic                              w_do_pop;

    always_comb begin
        o_full    = (r_count == sdse_pkg::CMDQ_CNT_W'(sdse_pkg::CMDQ_DEPTH));
        o_valid   = (r_count != '0);
        o_cmd     = r_slot[r_rd_ptr];
        w_do_push = i_push && !o_full;
        w_do_pop  = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: src/sdse_back.sv
// Back part: dictionary memory, lookahead window, priority scan and result register.
module sdse_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  sdse_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    input  logic [sdse_pkg::CFG_W-1:0]    i_limit,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [sdse_pkg::CODE_W-1:0]   o_code,
    output logic                          o_end_of_string
);

    localparam int NE = sdse_pkg::DICT_ENTRIES;
    localparam int NL = sdse_pkg::MAX_ENTRY_LEN;

    logic [NL-1:0][sdse_pkg::BYTE_W-1:0]  r_dict_mem [NE];
    logic [sdse_pkg::LEN_W-1:0]           r_len_mem  [NE];
    logic [NE-1:0]                        r_len_vld;

    sdse_pkg::t_back_state                r_state;
    sdse_pkg::t_back_state                n_state;

    logic [NL-1:0][sdse_pkg::BYTE_W-1:0]  r_win;
    logic [sdse_pkg::LEN_W-1:0]           r_count;
    logic                                 r_flush;

    logic [sdse_pkg::LIMIT_W-1:0]         r_issue;
    logic                                 r_cmp_live;
    logic [sdse_pkg::IDX_W-1:0]           r_cmp_idx;
    logic [NL-1:0][sdse_pkg::BYTE_W-1:0]  r_row;
    logic [sdse_pkg::LEN_W-1:0]           r_row_len;
    logic                                 r_row_vld;

    logic [sdse_pkg::CODE_W-1:0]          r_code;
    logic [sdse_pkg::LEN_W-1:0]           r_used;

    logic                                 r_out_vld;
    logic [sdse_pkg::CODE_W-1:0]          r_out_code;
    logic                                 r_out_eos;

    logic [sdse_pkg::LIMIT_W-1:0]         w_limit;
    logic                                 w_limit_zero;
    logic [sdse_pkg::LEN_W-1:0]           w_len_eff;
    logic [NL-1:0]                        w_match;
    logic                                 w_hit;
    logic                                 w_scan_done;
    logic [sdse_pkg::CODE_W-1:0]          w_hit_code;
    logic [sdse_pkg::LEN_W-1:0]           w_remaining;
    logic                                 w_is_load;
    logic                                 w_is_text;
    logic                                 w_text_full;
    logic                                 w_rd_en;
    logic [sdse_pkg::IDX_W-1:0]           w_rd_addr;
    logic                                 w_emit_go;

    always_comb begin
        if (i_limit > sdse_pkg::CFG_W'(NE)) begin
            w_limit = sdse_pkg::LIMIT_W'(NE);
        end else begin
            w_limit = i_limit[sdse_pkg::LIMIT_W-1:0];
        end
        w_limit_zero = (w_limit == '0);
    end

    always_comb begin
        w_len_eff = r_row_vld ? r_row_len : '0;
        for (int x = 0; x < NL; x++) begin
            w_match[x] = (sdse_pkg::LEN_W'(x) >= w_len_eff) || (r_row[x] == r_win[x]);
        end
        w_hit       = r_cmp_live && (w_len_eff != '0) && (w_len_eff <= r_count) && (&w_match);
        w_scan_done = r_cmp_live && !w_hit
                   && (sdse_pkg::LIMIT_W'(r_cmp_idx) == (w_limit - sdse_pkg::LIMIT_W'(1)));
        w_hit_code  = sdse_pkg::CODE_W'(sdse_pkg::CODE_BASE) + sdse_pkg::CODE_W'(r_cmp_idx);
        w_remaining = r_count - r_used;
        w_is_load   = i_cmd.kind == sdse_pkg::CMD_LOAD;
        w_is_text   = i_cmd.kind == sdse_pkg::CMD_TEXT;
        w_text_full = (r_count + sdse_pkg::LEN_W'(1)) == sdse_pkg::LEN_W'(NL);
        w_rd_addr   = r_issue[sdse_pkg::IDX_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sdse_pkg::ST_IDLE: begin
                if (o_cmd_pop && w_is_text && (w_text_full || i_cmd.last)) begin
                    n_state = sdse_pkg::ST_DECIDE;
                end
            end
            sdse_pkg::ST_DECIDE: begin
                n_state = w_limit_zero ? sdse_pkg::ST_EMIT : sdse_pkg::ST_SCAN;
            end
            sdse_pkg::ST_SCAN: begin
                if (w_hit || w_scan_done) begin
                    n_state = sdse_pkg::ST_EMIT;
                end
            end
            sdse_pkg::ST_EMIT: begin
                if (w_emit_go) begin
                    n_state = (r_flush && (w_remaining != '0)) ? sdse_pkg::ST_DECIDE
                                                               : sdse_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop = (r_state == sdse_pkg::ST_IDLE) && i_cmd_valid;
        w_rd_en   = (r_state == sdse_pkg::ST_SCAN) && (r_issue < w_limit) && !w_hit;
        w_emit_go = (r_state == sdse_pkg::ST_EMIT) && (!r_out_vld || i_pop);
        o_empty         = !r_out_vld;
        o_code          = r_out_code;
        o_end_of_string = r_out_eos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sdse_pkg::ST_IDLE;
            r_count    <= '0;
            r_len_vld  <= '0;
            r_cmp_live <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_live <= w_rd_en;
            if (o_cmd_pop && w_is_load && i_cmd.last) begin
                r_len_vld[i_cmd.entry] <= 1'b1;
            end
            if (o_cmd_pop && w_is_text) begin
                r_count <= r_count + sdse_pkg::LEN_W'(1);
            end else if (w_emit_go) begin
                r_count <= w_remaining;
            end
            if (w_emit_go) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && w_is_load) begin
            r_dict_mem[i_cmd.entry][i_cmd.pos] <= i_cmd.data;
            if (i_cmd.last) begin
                r_len_mem[i_cmd.entry] <= sdse_pkg::LEN_W'(i_cmd.pos) + sdse_pkg::LEN_W'(1);
            end
        end
        if (w_rd_en) begin
            r_row     <= r_dict_mem[w_rd_addr];
            r_row_len <= r_len_mem[w_rd_addr];
            r_row_vld <= r_len_vld[w_rd_addr];
            r_cmp_idx <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && w_is_text) begin
            r_win[r_count[sdse_pkg::POS_W-1:0]] <= i_cmd.data;
            r_flush <= i_cmd.last;
        end else if (w_emit_go) begin
            r_win <= r_win >> {r_used, 3'b000};
        end

        case (r_state)
            sdse_pkg::ST_DECIDE: begin
                r_issue <= '0;
                if (w_limit_zero) begin
                    r_code <= r_win[0];
                    r_used <= sdse_pkg::LEN_W'(1);
                end
            end
            sdse_pkg::ST_SCAN: begin
                if (w_rd_en) begin
                    r_issue <= r_issue + sdse_pkg::LIMIT_W'(1);
                end
                if (w_hit) begin
                    r_code <= w_hit_code;
                    r_used <= w_len_eff;
                end else if (w_scan_done) begin
                    r_code <= r_win[0];
                    r_used <= sdse_pkg::LEN_W'(1);
                end
            end
            default: begin
            end
        endcase

        if (w_emit_go) begin
            r_out_code <= r_code;
            r_out_eos  <= r_flush && (w_remaining == '0);
        end
    end

endmodule

FILE: src/static_dictionary_substitution_encoder_top.sv
// Top level of the static dictionary substitution encoder: config register and part wiring.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------------
//  input    | push / full               | i_mode i_entry_index i_char_pos i_data_byte i_last
//  result   | empty / pop               | o_code o_end_of_string
//  config   | psel penable pwrite pready| paddr pwdata prdata (entries_in_use at 0x0)
//
// A dictionary load or a text byte that starts no decision is taken while the back part stays idle.
// Each encoding decision passes DECIDE, SCAN and EMIT, and the scan ends early on a hit;
// with no entry to search DECIDE goes straight to EMIT. The scan reads one dictionary row per cycle.
// Synchronous active-low reset clears the queue, window count, entry valid flags and register.
// A four-deep command queue keeps the input open while the back part scans or a result waits.
module static_dictionary_substitution_encoder_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sdse_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [sdse_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [sdse_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  i_mode,
    input  logic [sdse_pkg::ENTRY_FIELD_W-1:0]    i_entry_index,
    input  logic [sdse_pkg::POS_FIELD_W-1:0]      i_char_pos,
    input  logic [sdse_pkg::BYTE_W-1:0]           i_data_byte,
    input  logic                                  i_last,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [sdse_pkg::CODE_W-1:0]           o_code,
    output logic                                  o_end_of_string
);

    logic [sdse_pkg::CFG_W-1:0] r_entries_in_use;
    logic                       w_reg_sel;
    logic                       w_q_full;
    logic                       w_q_push;
    sdse_pkg::t_cmd             w_front_cmd;
    logic                       w_q_valid;
    sdse_pkg::t_cmd             w_q_cmd;
    logic                       w_q_pop;

    always_comb begin
        pready    = 1'b1;
        w_reg_sel = (paddr[2] == sdse_pkg::REG_ENTRIES_IN_USE);
        prdata    = w_reg_sel ? sdse_pkg::APB_DATA_W'(r_entries_in_use) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= '0;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_entries_in_use <= pwdata[sdse_pkg::CFG_W-1:0];
        end
    end

    sdse_front u_front (
        .i_push        (push),
        .i_mode        (i_mode),
        .i_entry_index (i_entry_index),
        .i_char_pos    (i_char_pos),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .i_q_full      (w_q_full),
        .o_full        (full),
        .o_q_push      (w_q_push),
        .o_cmd         (w_front_cmd)
    );

    sdse_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    sdse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_q_valid),
        .i_cmd           (w_q_cmd),
        .o_cmd_pop       (w_q_pop),
        .i_limit         (r_entries_in_use),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_code          (o_code),
        .o_end_of_string (o_end_of_string)
    );

endmodule

FILE: src/sdse_checker.sv
// Port-level checks of the encoder top level, bound to it.
module sdse_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sdse_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [sdse_pkg::APB_DATA_W-1:0]       pwdata,
    input  logic [sdse_pkg::APB_DATA_W-1:0]       prdata,
    input  logic                                  pready,
    input  logic                                  push,
    input  logic                                  full,
    input  logic                                  empty,
    input  logic                                  pop,
    input  logic [sdse_pkg::CODE_W-1:0]           o_code,
    input  logic                                  o_end_of_string
);

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("results or full queue visible right after reset");

    a_result_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_code) && $stable(o_end_of_string))
        else $error("stalled result changed");

    a_cfg_readback : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[2] == sdse_pkg::REG_ENTRIES_IN_USE)
        ##1 (paddr[2] == sdse_pkg::REG_ENTRIES_IN_USE)
        |-> (prdata[sdse_pkg::CFG_W-1:0] == $past(pwdata[sdse_pkg::CFG_W-1:0]))
         && (prdata[sdse_pkg::APB_DATA_W-1:sdse_pkg::CFG_W] == '0))
        else $error("register readback differs from the last write");

    a_no_result_after_idle_reset : assert property (@(posedge i_clk)
        !i_rst_n ##1 !push |-> empty)
        else $error("result appeared without a text transfer");

endmodule

bind static_dictionary_substitution_encoder_top sdse_checker u_sdse_checker (.*);

FILE: bench/tb_static_dictionary_substitution_encoder_top.sv
// Self-checking testbench for the static dictionary substitution encoder top level.
module tb_static_dictionary_substitution_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sdse_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 4 * (DICT_ENTRIES + 4);
    localparam int PHASE_ITEMS    = 112;

    localparam logic [BYTE_W-1:0] CHAR_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_B = 8'h62;
    localparam logic [BYTE_W-1:0] CHAR_X = 8'h78;

    typedef struct {
        t_cmd_kind                mode;
        logic [ENTRY_FIELD_W-1:0] entry;
        logic [POS_FIELD_W-1:0]   pos;
        logic [BYTE_W-1:0]        data;
        logic                     last;
    } t_enc_item;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              eos;
    } t_code_result;

    logic                     i_clk;
    logic                     i_rst_n         = 1'b0;
    logic                     psel            = 1'b0;
    logic                     penable         = 1'b0;
    logic                     pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr           = '0;
    logic [APB_DATA_W-1:0]    pwdata          = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     push            = 1'b0;
    logic                     full;
    logic                     i_mode          = 1'b0;
    logic [ENTRY_FIELD_W-1:0] i_entry_index   = '0;
    logic [POS_FIELD_W-1:0]   i_char_pos      = '0;
    logic [BYTE_W-1:0]        i_data_byte     = '0;
    logic                     i_last          = 1'b0;
    logic                     empty;
    logic                     pop             = 1'b0;
    logic [CODE_W-1:0]        o_code;
    logic                     o_end_of_string;

    static_dictionary_substitution_encoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .i_mode          (i_mode),
        .i_entry_index   (i_entry_index),
        .i_char_pos      (i_char_pos),
        .i_data_byte     (i_data_byte),
        .i_last          (i_last),
        .empty           (empty),
        .pop             (pop),
        .o_code          (o_code),
        .o_end_of_string (o_end_of_string)
    );

    // encoder state as the testbench sees it
    logic [BYTE_W-1:0]        dict_mem [DICT_ENTRIES][MAX_ENTRY_LEN];
    logic [3:0]               dict_len [DICT_ENTRIES];
    logic [MAX_ENTRY_LEN-1:0] loaded_mask [DICT_ENTRIES];
    logic [BYTE_W-1:0]        win_mem [MAX_ENTRY_LEN];
    int                       win_cnt;
    logic [CFG_W-1:0]         reg_entries;

    t_code_result pending_codes[$];
    t_code_result want_code;
    int           mismatch_count = 0;
    int           items_sent     = 0;
    int           quiet_cycles   = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CODE_W-1:0] decide_code();
        int                lim;
        int                len;
        int                used;
        int                p;
        int                x;
        logic              match;
        logic              found;
        logic [CODE_W-1:0] code;
        code  = win_mem[0];
        used  = 1;
        found = 1'b0;
        lim   = (int'(reg_entries) > DICT_ENTRIES) ? DICT_ENTRIES : int'(reg_entries);
        for (p = 0; p < lim && !found; p++) begin
            len = int'(dict_len[p]);
            if (len != 0 && len <= win_cnt) begin
                match = 1'b1;
                for (x = 0; x < len; x++) begin
                    if (dict_mem[p][x] != win_mem[x]) match = 1'b0;
                end
                if (match) begin
                    found = 1'b1;
                    code  = CODE_W'(CODE_BASE + p);
                    used  = len;
                end
            end
        end
        if (used > win_cnt) used = win_cnt;
        for (x = 0; x + used < MAX_ENTRY_LEN; x++) win_mem[x] = win_mem[x + used];
        win_cnt -= used;
        return code;
    endfunction

    function automatic void predict_codes(t_enc_item it);
        t_code_result r;
        int           n;
        if (it.mode == CMD_LOAD) begin
            if (int'(it.entry) < DICT_ENTRIES && int'(it.pos) < MAX_ENTRY_LEN) begin
                dict_mem[it.entry][it.pos] = it.data;
                if (it.last) dict_len[it.entry] = it.pos + 4'd1;
            end
        end else begin
            if (win_cnt < MAX_ENTRY_LEN) begin
                win_mem[win_cnt] = it.data;
                win_cnt++;
            end
            if (!it.last) begin
                if (win_cnt >= MAX_ENTRY_LEN) begin
                    r.code = decide_code();
                    r.eos  = 1'b0;
                    pending_codes.push_back(r);
                end
            end else begin
                n = 0;
                while (win_cnt > 0 && n < MAX_ENTRY_LEN) begin
                    r.code = decide_code();
                    r.eos  = (win_cnt == 0);
                    pending_codes.push_back(r);
                    n++;
                end
            end
        end
    endfunction

    task automatic send_item(t_enc_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_mode        <= it.mode;
        i_entry_index <= it.entry;
        i_char_pos    <= it.pos;
        i_data_byte   <= it.data;
        i_last        <= it.last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_codes(it);
        items_sent++;
    endtask

    task automatic send_load(int entry, int pos, logic [BYTE_W-1:0] data, logic last);
        t_enc_item it;
        int        x;
        logic      covered;
        covered = 1'b1;
        if (pos < MAX_ENTRY_LEN) begin
            loaded_mask[entry][pos] = 1'b1;
            for (x = 0; x <= pos; x++) covered &= loaded_mask[entry][x];
            // never give an entry a length over bytes that were not loaded
            if (!covered) last = 1'b0;
        end
        it.mode  = CMD_LOAD;
        it.entry = ENTRY_FIELD_W'(entry);
        it.pos   = POS_FIELD_W'(pos);
        it.data  = data;
        it.last  = last;
        send_item(it);
    endtask

    task automatic send_text(logic [BYTE_W-1:0] data, logic last);
        t_enc_item it;
        it.mode  = CMD_TEXT;
        it.entry = ENTRY_FIELD_W'($urandom_range(DICT_ENTRIES - 1));
        it.pos   = POS_FIELD_W'($urandom_range(15));
        it.data  = data;
        it.last  = last;
        send_item(it);
    endtask

    task automatic settle_encoder();
        push <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_entries_in_use(logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ENTRIES_IN_USE, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        reg_entries = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_random_word();
        int e;
        int len;
        int x;
        e   = ($urandom_range(3) == 0) ? $urandom_range(DICT_ENTRIES - 1) : $urandom_range(15);
        len = ($urandom_range(7) == 0) ? MAX_ENTRY_LEN : $urandom_range(1, 4);
        for (x = 0; x < len; x++) begin
            send_load(e, x, ($urandom_range(9) == 0) ? BYTE_W'($urandom_range(255))
                                                     : BYTE_W'(CHAR_A + $urandom_range(3)),
                      x == len - 1);
        end
    endtask

    task automatic send_noise_load();
        send_load($urandom_range(DICT_ENTRIES - 1), $urandom_range(15),
                  BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic send_random_string();
        logic [BYTE_W-1:0] text[$];
        int                len;
        int                e;
        int                x;
        logic              ends;
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 12);
        while (text.size() < len) begin
            e = ($urandom_range(3) == 0) ? $urandom_range(DICT_ENTRIES - 1) : $urandom_range(15);
            if ($urandom_range(1) == 0 && dict_len[e] != 0) begin
                for (x = 0; x < int'(dict_len[e]); x++) text.push_back(dict_mem[e][x]);
            end else begin
                text.push_back(($urandom_range(2) != 0) ? BYTE_W'(CHAR_A + $urandom_range(3))
                                                        : BYTE_W'($urandom_range(255)));
            end
        end
        ends = ($urandom_range(9) != 0);
        for (x = 0; x < text.size(); x++) begin
            if ($urandom_range(19) == 0) send_noise_load();
            send_text(text[x], ends && (x == text.size() - 1));
        end
    endtask

    task automatic test_literals();
        write_entries_in_use(8'd0);
        send_load(0, 0, CHAR_A, 1'b1);
        send_text(CHAR_A, 1'b0);
        send_text(8'h00, 1'b0);
        send_text(8'h7F, 1'b0);
        send_text(8'h80, 1'b0);
        send_text(8'hFF, 1'b1);
        settle_encoder();
    endtask

    task automatic test_entry_priority();
        send_load(1, 0, CHAR_A, 1'b0);
        send_load(1, 1, CHAR_B, 1'b1);
        send_load(DICT_ENTRIES - 1, 0, CHAR_X, 1'b1);
        send_load(5, 15, 8'hFF, 1'b1);
        settle_encoder();
        write_entries_in_use(CFG_W'(DICT_ENTRIES));
        send_text(CHAR_A, 1'b0);
        send_text(CHAR_B, 1'b0);
        send_text(CHAR_X, 1'b1);
        settle_encoder();
    endtask

    task automatic test_full_window();
        send_text(CHAR_A, 1'b0);
        repeat (MAX_ENTRY_LEN - 1) send_text(CHAR_B, 1'b0);
        send_text(CHAR_X, 1'b1);
        settle_encoder();
    endtask

    task automatic run_random_phase(int send_pct, int recv_pct, logic [CFG_W-1:0] limit);
        int start;
        int r;
        settle_encoder();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_entries_in_use(limit);
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r < 18) load_random_word();
            else if (r < 25) send_noise_load();
            else send_random_string();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected transfer expected none actual code %0h end_of_string %0b",
                         $time, o_code, o_end_of_string);
                mismatch_count++;
            end else begin
                want_code = pending_codes.pop_front();
                if (o_code !== want_code.code) begin
                    $display("%0t: code mismatch expected %0h actual %0h",
                             $time, want_code.code, o_code);
                    mismatch_count++;
                end
                if (o_end_of_string !== want_code.eos) begin
                    $display("%0t: end_of_string mismatch expected %0b actual %0b",
                             $time, want_code.eos, o_end_of_string);
                    mismatch_count++;
                end
            end
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_static_dictionary_substitution_encoder_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int e = 0; e < DICT_ENTRIES; e++) begin
            dict_len[e]    = '0;
            loaded_mask[e] = '0;
        end
        win_cnt       = 0;
        reg_entries   = '0;
        send_idle_pct = 37;
        recv_idle_pct = 47;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_literals();
        test_entry_priority();
        test_full_window();
        run_random_phase(37, 47, 8'hFF);
        run_random_phase(47, 37, CFG_W'($urandom_range(1, 24)));
        run_random_phase(0, 0, CFG_W'(DICT_ENTRIES));
        settle_encoder();
        if (mismatch_count == 0 && pending_codes.size() == 0) begin
            $display("tb_static_dictionary_substitution_encoder_top OK");
        end else begin
            $display("tb_static_dictionary_substitution_encoder_top NOT OK");
        end
        $finish;
    end

endmodule
